FILE: src/gap_pkg.sv
// ----------------------------------------------------------------------------
// gap_pkg
// Shared types, constants and helpers for the grid A* path search block.
// ----------------------------------------------------------------------------
package gap_pkg;

    // grid geometry: a cell address is {z, x}
    localparam int GRID_SIDE = 64;
    localparam int COORD_W   = 6;
    localparam int CELL_W    = 2 * COORD_W;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int DIM_W     = 7;

    // node pool and path store
    localparam int POOL_SIZE  = 1024;
    localparam int POOL_W     = 10;
    localparam int CNT_W      = POOL_W + 1;
    localparam int PATH_DEPTH = POOL_SIZE + 1;

    // fixed point costs
    localparam int FRAC_BITS = 8;
    localparam int COST_W    = 19;
    localparam int SUMSQ_W   = 2 * COORD_W + 1;
    localparam int SQ_IN_W   = ((SUMSQ_W + 2 * FRAC_BITS + 1) / 2) * 2;
    localparam int SQ_OUT_W  = SQ_IN_W / 2;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    function automatic int isqrt_const(input int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    localparam int STEP_STRAIGHT = 1 << FRAC_BITS;
    localparam int STEP_DIAG     = isqrt_const(2 << (2 * FRAC_BITS));

    // neighbor order: +x, -x, +z, -z, then the four diagonals
    localparam logic [1:0] STEP_DX [8] = '{2'b01, 2'b11, 2'b00, 2'b00,
                                           2'b01, 2'b01, 2'b11, 2'b11};
    localparam logic [1:0] STEP_DZ [8] = '{2'b00, 2'b00, 2'b01, 2'b11,
                                           2'b01, 2'b11, 2'b01, 2'b11};

    // item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_FOUND    = 3'd1;
    localparam logic [2:0] ST_NO_PATH  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    // cell status codes
    localparam logic [1:0] CS_UNSEEN = 2'd0;
    localparam logic [1:0] CS_OPEN   = 2'd1;
    localparam logic [1:0] CS_CLOSED = 2'd2;

    // configuration register indexes
    localparam logic REG_GRID_W = 1'b0;
    localparam logic REG_GRID_H = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_z;
        logic [COORD_W-1:0] goal_x;
        logic [COORD_W-1:0] goal_z;
        logic               walkable;
        logic [CNT_W-1:0]   path_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [CNT_W-1:0]   path_length;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_z;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic       clr_en;
        logic       clr_walk;
        logic       load_wr;
        logic       path_rd;
        logic       pool_reset;
        logic       single_path;
        logic       h_prep;
        logic       h_sel_nb;
        logic       h_go;
        logic       node0_init;
        logic       scan_init;
        logic       scan_rd;
        logic       sel;
        logic       exp_latch;
        logic       d_init;
        logic       d_next;
        logic       nb_rd;
        logic       node_add;
        logic       pc_init;
        logic       pc_rd;
        logic       pc_step;
        logic       pw_init;
        logic       pw_rd;
        logic       pw_step;
        logic       res_load;
        logic       res_path;
        logic [2:0] res_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       clr_last;
        logic       read_ok;
        logic       start_is_goal;
        logic       sq_done;
        logic       scan_done;
        logic       any;
        logic       nb_ok;
        logic       nb_goal;
        logic       pool_full;
        logic       d_last;
        logic       idx_zero;
        logic       n_zero;
    } t_sts;

    function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W:0] v);
        return v[COST_W] ? COST_MAX : v[COST_W-1:0];
    endfunction

endpackage

FILE: src/gap_if.sv
// ----------------------------------------------------------------------------
// gap_in_if / gap_out_if
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
interface gap_in_if import gap_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gap_out_if import gap_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/gap_isqrt.sv
// ----------------------------------------------------------------------------
// gap_isqrt
// Floored integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module gap_isqrt import gap_pkg::*; #(
    parameter int IN_W  = SQ_IN_W,
    parameter int OUT_W = SQ_OUT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IN_W-1:0]  i_val,
    output logic [OUT_W-1:0] o_root,
    output logic             o_done
);
    localparam int ITER_W = $clog2(OUT_W + 1);

    logic [OUT_W+1:0]  r_rem;
    logic [OUT_W-1:0]  r_root;
    logic [IN_W-1:0]   r_val;
    logic [ITER_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [OUT_W+1:0] rem_sh;
    logic [OUT_W+1:0] trial;
    logic             fits;

    // one restoring step: bring down two bits, try root*4+1
    assign rem_sh = {r_rem[OUT_W-1:0], r_val[IN_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == ITER_W'(OUT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_val  <= i_val;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? rem_sh - trial : rem_sh;
            r_root <= {r_root[OUT_W-2:0], fits};
            r_val  <= r_val << 2;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;
endmodule

FILE: src/gap_datapath.sv
// ----------------------------------------------------------------------------
// gap_datapath
// Map, node pool and path memories, cost arithmetic and result register.
// ----------------------------------------------------------------------------
module gap_datapath import gap_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  t_in_item         i_item,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [DIM_W-1:0] i_cfg_wdata,
    output t_out_item        o_res
);
    // memories
    logic                 m_walk   [CELLS];
    logic [1:0]           m_cstat  [CELLS];
    logic [CELL_W-1:0]    m_coord  [POOL_SIZE];
    logic [POOL_W-1:0]    m_parent [POOL_SIZE];
    logic [COST_W-1:0]    m_g      [POOL_SIZE];
    logic [COST_W-1:0]    m_f      [POOL_SIZE];
    logic                 m_open   [POOL_SIZE];
    logic [CELL_W-1:0]    m_path   [PATH_DEPTH];

    // registered read data
    logic                 r_walk_q;
    logic [1:0]           r_cst_q;
    logic [CELL_W-1:0]    r_coord_q;
    logic [POOL_W-1:0]    r_parent_q;
    logic [COST_W-1:0]    r_g_q;
    logic [COST_W-1:0]    r_f_q;
    logic                 r_open_q;
    logic [CELL_W-1:0]    r_path_q;

    // working registers
    t_in_item             r_item;
    logic [DIM_W-1:0]     r_gw;
    logic [DIM_W-1:0]     r_gh;
    logic [CELL_W-1:0]    r_clr_cnt;
    logic [CNT_W-1:0]     r_pool_cnt;
    logic [CNT_W-1:0]     r_scan_i;
    logic                 r_cmp_vld;
    logic [POOL_W-1:0]    r_cmp_idx;
    logic                 r_any;
    logic [POOL_W-1:0]    r_best;
    logic [COST_W-1:0]    r_best_f;
    logic [COORD_W-1:0]   r_cur_x;
    logic [COORD_W-1:0]   r_cur_z;
    logic [COST_W-1:0]    r_cur_g;
    logic [2:0]           r_d;
    logic [SUMSQ_W-1:0]   r_sumsq;
    logic [COST_W-1:0]    r_g_new;
    logic [POOL_W-1:0]    r_idx;
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_path_len;
    t_out_item            r_res;

    // ------------------------------------------------------------------
    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= DIM_W'(GRID_SIDE);
            r_gh <= DIM_W'(GRID_SIDE);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_GRID_W: r_gw <= i_cfg_wdata;
                REG_GRID_H: r_gh <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // neighbor of the current node
    logic [1:0]         dx_s, dz_s;
    logic [COORD_W+1:0] nb_x, nb_z;
    logic [DIM_W-1:0]   w_eff, h_eff;
    logic               nb_in;
    logic [CELL_W-1:0]  nb_addr;

    assign dx_s  = STEP_DX[r_d];
    assign dz_s  = STEP_DZ[r_d];
    assign nb_x  = {2'b00, r_cur_x} + {{COORD_W{dx_s[1]}}, dx_s};
    assign nb_z  = {2'b00, r_cur_z} + {{COORD_W{dz_s[1]}}, dz_s};
    assign w_eff = (r_gw > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : r_gw;
    assign h_eff = (r_gh > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : r_gh;
    assign nb_in = !nb_x[COORD_W+1] && (nb_x[DIM_W-1:0] < w_eff) &&
                   !nb_z[COORD_W+1] && (nb_z[DIM_W-1:0] < h_eff);
    assign nb_addr = {nb_z[COORD_W-1:0], nb_x[COORD_W-1:0]};

    // ------------------------------------------------------------------
    // heuristic: squared distance, then the root unit
    logic [COORD_W-1:0]  tx, tz, adx, adz;
    logic [SQ_IN_W-1:0]  sq_in;
    logic [SQ_OUT_W-1:0] h_val;
    logic                sq_done;

    assign tx  = i_cmd.h_sel_nb ? nb_x[COORD_W-1:0] : r_item.cell_x;
    assign tz  = i_cmd.h_sel_nb ? nb_z[COORD_W-1:0] : r_item.cell_z;
    assign adx = (tx > r_item.goal_x) ? tx - r_item.goal_x : r_item.goal_x - tx;
    assign adz = (tz > r_item.goal_z) ? tz - r_item.goal_z : r_item.goal_z - tz;
    assign sq_in = SQ_IN_W'(r_sumsq) << (2 * FRAC_BITS);

    gap_isqrt #(
        .IN_W  (SQ_IN_W),
        .OUT_W (SQ_OUT_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.h_go),
        .i_val   (sq_in),
        .o_root  (h_val),
        .o_done  (sq_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.h_prep) begin
            r_sumsq <= SUMSQ_W'(adx) * SUMSQ_W'(adx) + SUMSQ_W'(adz) * SUMSQ_W'(adz);
            r_g_new <= sat_cost({1'b0, r_cur_g} +
                                (r_d[2] ? (COST_W+1)'(STEP_DIAG)
                                        : (COST_W+1)'(STEP_STRAIGHT)));
        end
    end

    // ------------------------------------------------------------------
    // walk map: cleared after reset, written by load items
    logic              walk_we, walk_wd;
    logic [CELL_W-1:0] walk_wa;

    always_comb begin
        walk_we = 1'b0;
        walk_wa = r_clr_cnt;
        walk_wd = 1'b0;
        if (i_cmd.clr_en && i_cmd.clr_walk) begin
            walk_we = 1'b1;
        end else if (i_cmd.load_wr) begin
            walk_we = 1'b1;
            walk_wa = {r_item.cell_z, r_item.cell_x};
            walk_wd = r_item.walkable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_we) m_walk[walk_wa] <= walk_wd;
        if (i_cmd.nb_rd) r_walk_q <= m_walk[nb_addr];
    end

    // ------------------------------------------------------------------
    // cell status: swept clear at search start
    logic              cst_we;
    logic [CELL_W-1:0] cst_wa;
    logic [1:0]        cst_wd;

    always_comb begin
        cst_we = 1'b0;
        cst_wa = r_clr_cnt;
        cst_wd = CS_UNSEEN;
        if (i_cmd.clr_en) begin
            cst_we = 1'b1;
        end else if (i_cmd.node0_init) begin
            cst_we = 1'b1;
            cst_wa = {r_item.cell_z, r_item.cell_x};
            cst_wd = CS_OPEN;
        end else if (i_cmd.exp_latch) begin
            cst_we = 1'b1;
            cst_wa = r_coord_q;
            cst_wd = CS_CLOSED;
        end else if (i_cmd.node_add) begin
            cst_we = 1'b1;
            cst_wa = nb_addr;
            cst_wd = CS_OPEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cst_we) m_cstat[cst_wa] <= cst_wd;
        if (i_cmd.nb_rd) r_cst_q <= m_cstat[nb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // node pool
    logic               node_we;
    logic [POOL_W-1:0]  node_wa;
    logic [CELL_W-1:0]  coord_wd;
    logic [COST_W-1:0]  g_wd;
    logic [COST_W-1:0]  f_wd;
    logic               open_we, open_wd;
    logic [POOL_W-1:0]  open_wa;
    logic [POOL_W-1:0]  coord_ra;

    assign node_we  = i_cmd.node0_init | i_cmd.node_add;
    assign node_wa  = i_cmd.node0_init ? '0 : r_pool_cnt[POOL_W-1:0];
    assign coord_wd = i_cmd.node0_init ? {r_item.cell_z, r_item.cell_x} : nb_addr;
    assign g_wd     = i_cmd.node0_init ? '0 : r_g_new;
    assign f_wd     = sat_cost({1'b0, g_wd} + (COST_W+1)'(h_val));

    assign open_we  = node_we | i_cmd.sel;
    assign open_wa  = i_cmd.sel ? r_best : node_wa;
    assign open_wd  = !i_cmd.sel;
    assign coord_ra = i_cmd.sel ? r_best : r_idx;

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            m_coord[node_wa]  <= coord_wd;
            m_parent[node_wa] <= i_cmd.node0_init ? '0 : r_best;
            m_g[node_wa]      <= g_wd;
            m_f[node_wa]      <= f_wd;
        end
        if (open_we) m_open[open_wa] <= open_wd;
        if (i_cmd.scan_rd) begin
            r_open_q <= m_open[r_scan_i[POOL_W-1:0]];
            r_f_q    <= m_f[r_scan_i[POOL_W-1:0]];
        end
        if (i_cmd.sel || i_cmd.pw_rd) r_coord_q <= m_coord[coord_ra];
        if (i_cmd.sel) r_g_q <= m_g[r_best];
        if (i_cmd.pc_rd || i_cmd.pw_rd) r_parent_q <= m_parent[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_cnt <= '0;
        end else if (i_cmd.pool_reset) begin
            r_pool_cnt <= '0;
        end else if (i_cmd.node0_init) begin
            r_pool_cnt <= CNT_W'(1);
        end else if (i_cmd.node_add) begin
            r_pool_cnt <= r_pool_cnt + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // open list scan for the least F, lowest index on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan_i <= '0;
            r_any    <= 1'b0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_scan_i  <= r_scan_i + 1'b1;
                r_cmp_idx <= r_scan_i[POOL_W-1:0];
            end
            if (r_cmp_vld && r_open_q && (!r_any || r_f_q < r_best_f)) begin
                r_any    <= 1'b1;
                r_best   <= r_cmp_idx;
                r_best_f <= r_f_q;
            end
        end
    end

    // current node and neighbor direction
    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_latch) begin
            r_cur_x <= r_coord_q[COORD_W-1:0];
            r_cur_z <= r_coord_q[CELL_W-1:COORD_W];
            r_cur_g <= r_g_q;
        end
        if (i_cmd.d_init) begin
            r_d <= '0;
        end else if (i_cmd.d_next) begin
            r_d <= r_d + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // path trace back and path store
    always_ff @(posedge i_clk) begin
        if (i_cmd.pc_init) begin
            r_idx <= r_best;
            r_n   <= CNT_W'(1);
        end else if (i_cmd.pc_step) begin
            r_idx <= r_parent_q;
            r_n   <= r_n + 1'b1;
        end else if (i_cmd.pw_init) begin
            r_idx <= r_best;
        end else if (i_cmd.pw_step) begin
            r_idx <= r_parent_q;
            r_n   <= r_n - 1'b1;
        end
    end

    logic              path_we;
    logic [CNT_W-1:0]  path_wa;
    logic [CELL_W-1:0] path_wd;

    always_comb begin
        path_we = 1'b0;
        path_wa = '0;
        path_wd = {r_item.cell_z, r_item.cell_x};
        if (i_cmd.single_path) begin
            path_we = 1'b1;
        end else if (i_cmd.pw_init) begin
            path_we = 1'b1;
            path_wa = r_n;
            path_wd = {r_item.goal_z, r_item.goal_x};
        end else if (i_cmd.pw_step) begin
            path_we = 1'b1;
            path_wa = r_n - 1'b1;
            path_wd = r_coord_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (path_we) m_path[path_wa] <= path_wd;
        if (i_cmd.path_rd) r_path_q <= m_path[r_item.path_index];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len <= '0;
        end else if (i_cmd.single_path) begin
            r_path_len <= CNT_W'(1);
        end else if (i_cmd.pw_init) begin
            r_path_len <= r_n + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // item capture and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_item <= i_item;
        if (i_cmd.res_load) begin
            r_res.status      <= i_cmd.res_status;
            r_res.path_length <= r_path_len;
            r_res.out_x       <= i_cmd.res_path ? r_path_q[COORD_W-1:0] : '0;
            r_res.out_z       <= i_cmd.res_path ? r_path_q[CELL_W-1:COORD_W] : '0;
        end
    end

    assign o_res = r_res;

    // status to the controller
    assign o_sts.kind          = r_item.kind;
    assign o_sts.clr_last      = r_clr_cnt == CELL_W'(CELLS - 1);
    assign o_sts.read_ok       = r_item.path_index < r_path_len;
    assign o_sts.start_is_goal = (r_item.cell_x == r_item.goal_x) &&
                                 (r_item.cell_z == r_item.goal_z);
    assign o_sts.sq_done       = sq_done;
    assign o_sts.scan_done     = r_scan_i == r_pool_cnt;
    assign o_sts.any           = r_any;
    assign o_sts.nb_ok         = nb_in && r_walk_q && (r_cst_q == CS_UNSEEN);
    assign o_sts.nb_goal       = (nb_x[COORD_W-1:0] == r_item.goal_x) &&
                                 (nb_z[COORD_W-1:0] == r_item.goal_z);
    assign o_sts.pool_full     = r_pool_cnt >= CNT_W'(POOL_SIZE);
    assign o_sts.d_last        = r_d == 3'd7;
    assign o_sts.idx_zero      = r_idx == '0;
    assign o_sts.n_zero        = r_n == '0;
endmodule

FILE: src/gap_ctrl.sv
// ----------------------------------------------------------------------------
// gap_ctrl
// Sequencer for load, read and search items; owns the channel handshakes.
// ----------------------------------------------------------------------------
module gap_ctrl import gap_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [4:0] S_INIT    = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DECODE  = 5'd2;
    localparam logic [4:0] S_RD_WAIT = 5'd3;
    localparam logic [4:0] S_CLR     = 5'd4;
    localparam logic [4:0] S_START   = 5'd5;
    localparam logic [4:0] S_H_PREP  = 5'd6;
    localparam logic [4:0] S_H_GO    = 5'd7;
    localparam logic [4:0] S_H_WAIT  = 5'd8;
    localparam logic [4:0] S_NODE0   = 5'd9;
    localparam logic [4:0] S_SCAN    = 5'd10;
    localparam logic [4:0] S_SEL     = 5'd11;
    localparam logic [4:0] S_EXP     = 5'd12;
    localparam logic [4:0] S_NB_RD   = 5'd13;
    localparam logic [4:0] S_NB_CHK  = 5'd14;
    localparam logic [4:0] S_NB_ADD  = 5'd15;
    localparam logic [4:0] S_PC_TEST = 5'd16;
    localparam logic [4:0] S_PC_WAIT = 5'd17;
    localparam logic [4:0] S_PW_INIT = 5'd18;
    localparam logic [4:0] S_PW_TEST = 5'd19;
    localparam logic [4:0] S_PW_WAIT = 5'd20;
    localparam logic [4:0] S_RESULT  = 5'd21;

    logic [4:0] r_state, n_state;
    logic       r_h_nb, n_h_nb;
    logic [2:0] r_res_st, n_res_st;
    logic       r_res_path, n_res_path;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_h_nb      <= 1'b0;
            r_res_st    <= ST_DONE;
            r_res_path  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_h_nb      <= n_h_nb;
            r_res_st    <= n_res_st;
            r_res_path  <= n_res_path;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.h_sel_nb = r_h_nb;
        o_cmd.res_path = r_res_path;
        o_cmd.res_status = r_res_st;
        n_state     = r_state;
        n_h_nb      = r_h_nb;
        n_res_st    = r_res_st;
        n_res_path  = r_res_path;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;

        case (r_state)
            S_INIT: begin
                o_cmd.clr_en   = 1'b1;
                o_cmd.clr_walk = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_st   = ST_DONE;
                n_res_path = 1'b0;
                n_state    = S_RESULT;
                case (i_sts.kind)
                    KIND_LOAD: begin
                        o_cmd.load_wr = 1'b1;
                    end
                    KIND_READ: begin
                        if (i_sts.read_ok) begin
                            o_cmd.path_rd = 1'b1;
                            n_res_path    = 1'b1;
                            n_state       = S_RD_WAIT;
                        end else begin
                            n_res_st = ST_RANGE;
                        end
                    end
                    KIND_SEARCH: begin
                        o_cmd.pool_reset = 1'b1;
                        n_state          = S_CLR;
                    end
                    default: ;
                endcase
            end
            S_RD_WAIT: begin
                n_state = S_RESULT;
            end
            S_CLR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) n_state = S_START;
            end
            S_START: begin
                if (i_sts.start_is_goal) begin
                    o_cmd.single_path = 1'b1;
                    n_res_st          = ST_FOUND;
                    n_state           = S_RESULT;
                end else begin
                    n_h_nb  = 1'b0;
                    n_state = S_H_PREP;
                end
            end
            S_H_PREP: begin
                o_cmd.h_prep = 1'b1;
                n_state      = S_H_GO;
            end
            S_H_GO: begin
                o_cmd.h_go = 1'b1;
                n_state    = S_H_WAIT;
            end
            S_H_WAIT: begin
                if (i_sts.sq_done) n_state = r_h_nb ? S_NB_ADD : S_NODE0;
            end
            S_NODE0: begin
                o_cmd.node0_init = 1'b1;
                o_cmd.scan_init  = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_SEL;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                end
            end
            S_SEL: begin
                if (!i_sts.any) begin
                    n_res_st = ST_NO_PATH;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.sel = 1'b1;
                    n_state   = S_EXP;
                end
            end
            S_EXP: begin
                o_cmd.exp_latch = 1'b1;
                o_cmd.d_init    = 1'b1;
                n_state         = S_NB_RD;
            end
            S_NB_RD: begin
                o_cmd.nb_rd = 1'b1;
                n_state     = S_NB_CHK;
            end
            S_NB_CHK: begin
                if (!i_sts.nb_ok) begin
                    if (i_sts.d_last) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end else begin
                        o_cmd.d_next = 1'b1;
                        n_state      = S_NB_RD;
                    end
                end else if (i_sts.nb_goal) begin
                    o_cmd.pc_init = 1'b1;
                    n_state       = S_PC_TEST;
                end else if (i_sts.pool_full) begin
                    n_res_st = ST_OVERFLOW;
                    n_state  = S_RESULT;
                end else begin
                    n_h_nb  = 1'b1;
                    n_state = S_H_PREP;
                end
            end
            S_NB_ADD: begin
                o_cmd.node_add = 1'b1;
                if (i_sts.d_last) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.d_next = 1'b1;
                    n_state      = S_NB_RD;
                end
            end
            // count the chain of parents
            S_PC_TEST: begin
                if (i_sts.idx_zero) begin
                    n_state = S_PW_INIT;
                end else begin
                    o_cmd.pc_rd = 1'b1;
                    n_state     = S_PC_WAIT;
                end
            end
            S_PC_WAIT: begin
                o_cmd.pc_step = 1'b1;
                n_state       = S_PC_TEST;
            end
            // write the chain back to front
            S_PW_INIT: begin
                o_cmd.pw_init = 1'b1;
                n_state       = S_PW_TEST;
            end
            S_PW_TEST: begin
                if (i_sts.n_zero) begin
                    n_res_st = ST_FOUND;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.pw_rd = 1'b1;
                    n_state     = S_PW_WAIT;
                end
            end
            S_PW_WAIT: begin
                o_cmd.pw_step = 1'b1;
                n_state       = S_PW_TEST;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

FILE: src/grid_astar_path_search.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search
// A* search over an 8-connected walkable grid with path read-back.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  i_in      in   valid/ready          t_in_item (kind, cells, goal, index)
//  o_out     out  valid/ready          t_out_item (status, length, cell)
//  i_cfg_*   in   write enable only    grid_width / grid_height
//
//  One item is worked at a time; every result waits for the output register
//  to drain. A search sweeps the cell status memory, then per expansion scans
//  the node pool one entry a cycle and checks each of the eight neighbors,
//  running the root unit for each new node. Path trace-back counts the parent
//  chain, then writes it back to front. After reset a pass clears the walk
//  map before the first item is taken.
// ----------------------------------------------------------------------------
module grid_astar_path_search import gap_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gap_in_if.sink           i_in,
    gap_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [DIM_W-1:0] i_cfg_wdata
);
    t_cmd      cmd;
    t_sts      sts;
    t_out_item res;

    gap_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gap_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (i_in.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (res)
    );

    assign o_out.data = res;
endmodule

FILE: src/gap_checker.sv
// ----------------------------------------------------------------------------
// gap_checker
// Port-level assertions for the grid A* path search block.
// ----------------------------------------------------------------------------
module gap_checker import gap_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result changed while stalled");

    // one item at a time: ready drops after a transaction
    a_in_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while busy");

    // a found path has at least one cell
    a_found_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status == ST_FOUND |-> i_out_data.path_length != 0)
        else $error("found path with zero length");

    // out of range read returns a zero cell
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status == ST_RANGE |->
            i_out_data.out_x == 0 && i_out_data.out_z == 0)
        else $error("out of range read returned a cell");
endmodule

bind grid_astar_path_search gap_checker u_gap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
